// File: hw/rtl/pge_pkg.sv
// ----------------------------------------------------------------------------
// pge_pkg: shared types, constants and table math
// Register codes, queue item type and the 2^-f table generator.
// ----------------------------------------------------------------------------
package pge_pkg;

  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned ExpDepthDef  = 256;
  localparam int unsigned ZqW          = 11;       // |z| < 8.0 in Q3.8
  localparam logic [63:0] Ln2Q32       = 64'd2977044472;
  localparam logic [15:0] HalfLog2eQ16 = 16'd47274;
  localparam int unsigned MaxShift     = 48;
  localparam int unsigned MidDepth     = 4;
  localparam int unsigned OutDepth     = 32;

  localparam logic [2:0] RegLow   = 3'd0;
  localparam logic [2:0] RegMid   = 3'd1;
  localparam logic [2:0] RegHigh  = 3'd2;
  localparam logic [2:0] RegBound = 3'd3;

  localparam logic [1:0] SegLow  = 2'd0;
  localparam logic [1:0] SegMid  = 2'd1;
  localparam logic [1:0] SegHigh = 2'd2;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]  seg;
    logic        zero;
    logic [15:0] amp;
    logic [15:0] mag_d;
    logic [15:0] mag_s;
  } pge_item_t;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  seg;
    logic        zero;
  } pge_res_t;

  function automatic logic [63:0] div_small(input logic [63:0] t, input int unsigned k);
    logic [63:0] r;
    case (k)
      1: r = t / 64'd1;   2: r = t / 64'd2;   3: r = t / 64'd3;   4: r = t / 64'd4;
      5: r = t / 64'd5;   6: r = t / 64'd6;   7: r = t / 64'd7;   8: r = t / 64'd8;
      9: r = t / 64'd9;   10: r = t / 64'd10; 11: r = t / 64'd11; 12: r = t / 64'd12;
      13: r = t / 64'd13; 14: r = t / 64'd14; 15: r = t / 64'd15; 16: r = t / 64'd16;
      17: r = t / 64'd17; 18: r = t / 64'd18; 19: r = t / 64'd19; 20: r = t / 64'd20;
      default: r = t;
    endcase
    return r;
  endfunction

  // exp(-a), a in Q.32, Taylor series up to the a^20 term with truncating steps
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] a);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [127:0] prod;
    term = 64'd1 << 32;
    pos  = term;
    neg  = '0;
    for (int k = 1; k <= 20; k++) begin
      prod = 128'(term) * 128'(a);
      term = div_small(prod[95:32], k);
      if (k % 2 == 1) neg = neg + term;
      else            pos = pos + term;
    end
    return (neg > pos) ? 64'd0 : pos - neg;
  endfunction

  // round a Q.32 value to dw fraction bits
  function automatic logic [63:0] round_to(input logic [63:0] t, input int unsigned dw);
    logic [63:0] r;
    if (dw >= 32) r = t;
    else r = (t + (64'd1 << (31 - dw))) >> (32 - dw);
    return r;
  endfunction

endpackage

// File: hw/rtl/pge_fifo.sv
// ----------------------------------------------------------------------------
// pge_fifo: small synchronous queue
// Register-array FIFO with wrap-bit pointers.
// ----------------------------------------------------------------------------
module pge_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);
  localparam int unsigned AW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW:0] wr_q, wr_d, rd_q, rd_d;

  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[AW-1:0] == rd_q[AW-1:0]) && (wr_q[AW] != rd_q[AW]);
  assign data_o  = mem_q[rd_q[AW-1:0]];

  assign wr_d = wr_q + ((push_i && !full_o) ? (AW+1)'(1) : '0);
  assign rd_d = rd_q + ((pop_i && !empty_o) ? (AW+1)'(1) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q[AW-1:0]] <= data_i;
  end
endmodule

// File: hw/rtl/pge_front.sv
// ----------------------------------------------------------------------------
// pge_front: segment classification
// Picks the Gaussian for x and forms |x-mean| and |sigma|.
// ----------------------------------------------------------------------------
module pge_front (
  input  logic signed [15:0] x_value_i,
  input  logic [47:0]        low_params_i,
  input  logic [47:0]        mid_params_i,
  input  logic [47:0]        high_params_i,
  input  logic [31:0]        bounds_i,
  output pge_pkg::pge_item_t item_o
);
  import pge_pkg::*;

  logic signed [15:0] b1, b2, mean, sigma;
  logic signed [16:0] diff;
  logic [47:0] par;
  logic [1:0]  seg;

  always_comb begin
    b1 = bounds_i[31:16];
    b2 = bounds_i[15:0];
    if (x_value_i <= b1) begin
      seg = SegLow;
      par = low_params_i;
    end else if (x_value_i <= b2) begin
      seg = SegMid;
      par = mid_params_i;
    end else begin
      seg = SegHigh;
      par = high_params_i;
    end
    mean  = par[31:16];
    sigma = par[15:0];
    diff  = 17'(x_value_i) - 17'(mean);
    item_o.seg   = seg;
    item_o.zero  = (sigma == 16'sd0);
    item_o.amp   = par[47:32];
    item_o.mag_d = diff[16] ? 16'(-diff) : diff[15:0];
    item_o.mag_s = sigma[15] ? 16'(-sigma) : sigma;
  end
endmodule

// File: hw/rtl/pge_back.sv
// ----------------------------------------------------------------------------
// pge_back: Gaussian evaluation pipeline
// Bit-per-stage divider for z, then z^2, 2^-u table and rounding shift.
// ----------------------------------------------------------------------------
module pge_back #(
  parameter int unsigned DataWidth = pge_pkg::DataWidthDef,
  parameter int unsigned ExpDepth  = pge_pkg::ExpDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  pge_pkg::pge_item_t item_i,
  output logic               valid_o,
  output pge_pkg::pge_res_t  res_o
);
  import pge_pkg::*;

  localparam int unsigned TW = $clog2(ExpDepth);
  localparam int unsigned IW = TW + 1;
  localparam int unsigned PW = DataWidth + 18;
  localparam int unsigned RW = 27;

  typedef struct packed {
    logic [1:0]    seg;
    logic          zero;
    logic          kill;
    logic [15:0]   amp;
    logic [15:0]   ms;
    logic [RW-1:0] rem;
    logic [ZqW-1:0] q;
  } div_t;

  typedef struct packed {
    logic [1:0]  seg;
    logic        zero;
    logic        kill;
    logic [15:0] amp;
    logic [6:0]  n;
  } tag_t;

  // constant 2^-(i/depth) table
  logic [DataWidth:0] tab [ExpDepth];
  for (genvar g = 0; g < ExpDepth; g++) begin : g_tab
    localparam logic [63:0] AG = (Ln2Q32 * g + ExpDepth / 2) / ExpDepth;
    localparam logic [63:0] TG = round_to(exp_neg_q32(AG), DataWidth);
    assign tab[g] = TG[DataWidth:0];
  end

  // divider: stage 0 prepares, stages 1..ZqW resolve one quotient bit each
  div_t dv_q [ZqW+1];
  logic dvv_q [ZqW+1];
  logic [RW-1:0] num, lim;

  always_comb begin
    num = RW'({item_i.mag_d, 8'b0}) + RW'(item_i.mag_s >> 1);
    lim = RW'({item_i.mag_s, 11'b0});
  end

  always_ff @(posedge clk_i) begin
    dv_q[0].seg  <= item_i.seg;
    dv_q[0].zero <= item_i.zero;
    dv_q[0].kill <= item_i.zero || (num >= lim);
    dv_q[0].amp  <= item_i.amp;
    dv_q[0].ms   <= item_i.mag_s;
    dv_q[0].rem  <= num;
    dv_q[0].q    <= '0;
  end

  for (genvar j = 1; j <= ZqW; j++) begin : g_div
    localparam int unsigned B = ZqW - j;
    div_t nx;
    logic [RW-1:0] trial;
    always_comb begin
      nx    = dv_q[j-1];
      trial = RW'(dv_q[j-1].ms) << B;
      if (dv_q[j-1].rem >= trial) begin
        nx.rem  = dv_q[j-1].rem - trial;
        nx.q[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) dv_q[j] <= nx;
  end

  // exponent stages
  tag_t t1_q, t2_q, t3_q, t4_q, t5_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [21:0] z2_q;
  logic [15:0] f_q;
  logic [TW-1:0] idx_q;
  logic [DataWidth:0] tv_q;
  logic [DataWidth+16:0] prod_q;

  logic [ZqW-1:0] zq;
  logic [38:0] uk;
  logic [16+IW-1:0] fx;
  logic [IW-1:0] ix;
  tag_t t3_d;
  logic [6:0] s5;
  logic [PW-1:0] rnd;
  logic [PW-1:0] shf;

  always_comb begin
    zq = dv_q[ZqW].q;
    uk = 39'(z2_q) * 39'(HalfLog2eQ16) + 39'd32768;
    fx = (16+IW)'(f_q) * (16+IW)'(ExpDepth) + (16+IW)'(32768);
    ix = fx[16+IW-1:16];
    t3_d = t2_q;
    if (ix >= IW'(ExpDepth)) begin
      ix = '0;
      t3_d.n = t2_q.n + 7'd1;
    end
    if (7'(DataWidth) + t3_d.n > 7'(MaxShift)) t3_d.kill = 1'b1;
    s5  = 7'(DataWidth) + t5_q.n;
    rnd = PW'(prod_q) + (PW'(1) << (s5 - 7'd1));
    shf = rnd >> s5;
  end

  always_ff @(posedge clk_i) begin
    t1_q   <= '{seg: dv_q[ZqW].seg, zero: dv_q[ZqW].zero, kill: dv_q[ZqW].kill,
                amp: dv_q[ZqW].amp, n: '0};
    z2_q   <= 22'(zq) * 22'(zq);
    t2_q   <= '{seg: t1_q.seg, zero: t1_q.zero, kill: t1_q.kill, amp: t1_q.amp,
                n: 7'(uk[38:32])};
    f_q    <= uk[31:16];
    t3_q   <= t3_d;
    idx_q  <= ix[TW-1:0];
    t4_q   <= t3_q;
    tv_q   <= tab[idx_q];
    t5_q   <= t4_q;
    prod_q <= (DataWidth+17)'(t4_q.amp) * (DataWidth+17)'(tv_q);
    res_o.value <= t5_q.kill ? 16'd0 : shf[15:0];
    res_o.seg   <= t5_q.seg;
    res_o.zero  <= t5_q.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= ZqW; k++) dvv_q[k] <= 1'b0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      dvv_q[0] <= valid_i;
      for (int k = 1; k <= ZqW; k++) dvv_q[k] <= dvv_q[k-1];
      v1_q <= dvv_q[ZqW];
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      valid_o <= v5_q;
    end
  end
endmodule

// File: hw/rtl/piecewise_gaussian_eval_top.sv
// ----------------------------------------------------------------------------
// piecewise_gaussian_eval_top: three-piece fixed-point Gaussian evaluator
// Classifies x by segment, queues it, and evaluates amp*exp(-z^2/2).
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake              | Payload
// input    | in        | push / full            | x_value_i
// result   | out       | empty / pop            | curve_value_o, segment_used_o,
//          |           |                        | sigma_zero_o
// config   | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle sustained while credits remain; the path from push to a
// non-empty result queue runs through the middle queue, one divider prep stage,
// the 11-stage quotient divider and six exponent stages. Reset clears
// queues and pipeline valids; registers return to their documented values.
// When the result queue backs up, credits stop issue from the middle queue,
// which then fills and raises full. Config writes are always ready.
// ----------------------------------------------------------------------------
module piecewise_gaussian_eval_top #(
  parameter int unsigned DataWidth = pge_pkg::DataWidthDef,
  parameter int unsigned ExpDepth  = pge_pkg::ExpDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] x_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] curve_value_o,
  output logic [1:0]  segment_used_o,
  output logic        sigma_zero_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  import pge_pkg::*;

  localparam int unsigned CW = $clog2(OutDepth + 1);

  // configuration registers
  logic [47:0] low_q, mid_q, high_q;
  logic [31:0] bnd_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= 48'd1;
      mid_q  <= 48'd1;
      high_q <= 48'd1;
      bnd_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLow:   low_q  <= cfg_data_i;
        RegMid:   mid_q  <= cfg_data_i;
        RegHigh:  high_q <= cfg_data_i;
        RegBound: bnd_q  <= cfg_data_i[31:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // front: classify straight into the middle queue
  pge_item_t item_in, item_mid;
  logic      mid_empty, issue;

  pge_front u_front (
    .x_value_i     (x_value_i),
    .low_params_i  (low_q),
    .mid_params_i  (mid_q),
    .high_params_i (high_q),
    .bounds_i      (bnd_q),
    .item_o        (item_in)
  );

  pge_fifo #(.Width($bits(pge_item_t)), .Depth(MidDepth)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_in),
    .pop_i   (issue),
    .full_o  (full),
    .empty_o (mid_empty),
    .data_o  (item_mid)
  );

  // credits: items in the back pipeline plus those in the result queue
  logic [CW-1:0] cred_q, cred_d;
  logic          out_pop;

  assign out_pop = pop && !empty;
  assign issue   = !mid_empty && (cred_q < CW'(OutDepth));
  assign cred_d  = cred_q + (issue ? CW'(1) : '0) - (out_pop ? CW'(1) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cred_q <= '0;
    else         cred_q <= cred_d;
  end

  // back: evaluation pipeline and result queue
  logic     bk_valid, res_full;
  pge_res_t bk_res, res_head;

  pge_back #(.DataWidth(DataWidth), .ExpDepth(ExpDepth)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (issue),
    .item_i  (item_mid),
    .valid_o (bk_valid),
    .res_o   (bk_res)
  );

  pge_fifo #(.Width($bits(pge_res_t)), .Depth(OutDepth)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_valid),
    .data_i  (bk_res),
    .pop_i   (pop),
    .full_o  (res_full),
    .empty_o (empty),
    .data_o  (res_head)
  );

  assign curve_value_o  = res_head.value;
  assign segment_used_o = res_head.seg;
  assign sigma_zero_o   = res_head.zero;

  // checks
  a_no_out_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bk_valid && res_full)) else $error("result queue overflow");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred_q <= CW'(OutDepth)) else $error("credit count out of range");

  a_zero_sigma_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && sigma_zero_o) |-> (curve_value_o == 16'd0))
    else $error("zero sigma with nonzero value");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (segment_used_o != 2'd3)) else $error("bad segment code");
endmodule

// File: bench/tb_piecewise_gaussian_eval_top.sv
// ----------------------------------------------------------------------------
// tb_piecewise_gaussian_eval_top: self-checking bench for the Gaussian evaluator
// Drives x items through the input queue, predicts each curve value from the
// register settings, and compares popped results in order. Random idling on
// both sides, a long pop hold-off to fill the block, and register phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_piecewise_gaussian_eval_top;
  import pge_pkg::*;

  localparam int unsigned DW         = 16;
  localparam int unsigned DEPTH      = 256;
  localparam int unsigned LATENCY    = 19;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned HOLD_LEN   = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [15:0] x_value_i;
  logic        empty;
  logic        pop;
  logic [15:0] curve_value_o;
  logic [1:0]  segment_used_o;
  logic        sigma_zero_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [47:0] cfg_data_i;

  piecewise_gaussian_eval_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .x_value_i      (x_value_i),
    .empty          (empty),
    .pop            (pop),
    .curve_value_o  (curve_value_o),
    .segment_used_o (segment_used_o),
    .sigma_zero_o   (sigma_zero_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  typedef struct {
    logic [15:0] value;
    logic [1:0]  seg;
    logic        zero;
  } curve_t;

  // predictor copy of the registers
  logic [47:0] gauss_reg [3];
  logic [31:0] bounds_reg;
  logic [63:0] pow2_frac [DEPTH];

  logic [15:0] x_pending [$];
  curve_t      curve_expected [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned hold_cnt;
  bit          hold_req;   // set by stimulus, starts a long pop hold-off
  bit          pause_tx;   // sender stops while set

  // handshake levels as seen at the rising edge
  logic full_q;
  logic empty_q;

  // --- table of 2^-(i/DEPTH), built in the bench's own terms --------------
  function automatic logic [63:0] taylor_exp_neg(input logic [63:0] a);
    logic [63:0]  term;
    logic [63:0]  sum_pos;
    logic [63:0]  sum_neg;
    logic [127:0] wide;
    term    = 64'd1 << 32;
    sum_pos = term;
    sum_neg = 0;
    for (int k = 1; k <= 20; k++) begin
      wide = 128'(term) * 128'(a);
      term = wide[95:32] / 64'(k);
      if (k[0]) sum_neg += term;
      else      sum_pos += term;
    end
    return (sum_neg > sum_pos) ? 64'd0 : sum_pos - sum_neg;
  endfunction

  function automatic curve_t predict_curve(input logic [15:0] x_raw);
    curve_t      r;
    int          x, lo_b, hi_b, mean, sig, delta;
    logic [47:0] p;
    logic [63:0] mag_s, mag_d, zq, u, n, f, idx, prod, sh;
    x    = $signed(x_raw);
    lo_b = $signed(bounds_reg[31:16]);
    hi_b = $signed(bounds_reg[15:0]);
    if (x <= lo_b)      r.seg = SegLow;
    else if (x <= hi_b) r.seg = SegMid;
    else                r.seg = SegHigh;
    p    = gauss_reg[r.seg];
    mean = $signed(p[31:16]);
    sig  = $signed(p[15:0]);
    r.zero  = (sig == 0);
    r.value = 0;
    if (!r.zero) begin
      mag_s = (sig < 0) ? -sig : sig;
      delta = x - mean;
      mag_d = (delta < 0) ? -delta : delta;
      zq    = (mag_d * 256 + mag_s / 2) / mag_s;
      if (zq > 64'hFFFF) zq = 64'hFFFF;
      if (zq < 2048) begin
        u   = (zq * zq * 64'd47274 + (64'd1 << 15)) >> 16;
        n   = u >> 16;
        f   = u & 64'hFFFF;
        idx = (f * DEPTH + (64'd1 << 15)) >> 16;
        if (idx >= DEPTH) begin
          idx = 0;
          n   = n + 1;
        end
        sh = DW + n;
        if (sh <= 48) begin
          prod    = 64'(p[47:32]) * pow2_frac[idx];
          r.value = 16'((prod + (64'd1 << (sh - 1))) >> sh);
        end
      end
    end
    return r;
  endfunction

  // --- clock and cycle limit ----------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --- driver: offers pending x items at falling edges ---------------------
  int unsigned tx_wait;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push    <= 1'b0;
      tx_wait <= 0;
    end else begin
      // item taken at the previous rising edge
      if (push && !full_q) begin
        curve_expected.push_back(predict_curve(x_value_i));
        items_sent <= items_sent + 1;
      end
      if (push && full_q) begin
        // still waiting for acceptance, hold item
      end else if (tx_wait != 0) begin
        tx_wait <= tx_wait - 1;
        push    <= 1'b0;
      end else if (x_pending.size() != 0 && !pause_tx) begin
        x_value_i <= x_pending.pop_front();
        push      <= 1'b1;
        tx_wait   <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) full_q <= full;

  // --- monitor: pops and checks results ------------------------------------
  int unsigned rx_wait;
  always @(posedge clk_i) begin
    curve_t want;
    if (rst_ni && pop && !empty) begin
      results_seen <= results_seen + 1;
      if (curve_expected.size() == 0) begin
        $error("result with nothing expected: value %0d", curve_value_o);
        errors++;
      end else begin
        want = curve_expected.pop_front();
        if (curve_value_o !== want.value) begin
          $error("curve_value expected %0d actual %0d", want.value, curve_value_o);
          errors++;
        end
        if (segment_used_o !== want.seg) begin
          $error("segment_used expected %0d actual %0d", want.seg, segment_used_o);
          errors++;
        end
        if (sigma_zero_o !== want.zero) begin
          $error("sigma_zero expected %0d actual %0d", want.zero, sigma_zero_o);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      rx_wait  <= 0;
      hold_cnt <= 0;
    end else if (hold_req && hold_cnt == 0) begin
      hold_cnt <= HOLD_LEN;
      hold_req <= 1'b0;
      pop      <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      pop      <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      pop     <= 1'b0;
    end else begin
      pop <= 1'b1;
      // a new wait is drawn once something was taken
      if (pop && !empty_q)
        rx_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    end
  end

  always @(posedge clk_i) empty_q <= empty;

  // --- register writes, only while the block is idle -----------------------
  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegLow, RegMid, RegHigh: gauss_reg[idx] = data;
      RegBound:                bounds_reg     = data[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_all();
    while (x_pending.size() != 0 || push || curve_expected.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [47:0] gauss_word(input logic [15:0] amp,
                                             input logic [15:0] mean,
                                             input logic [15:0] sig);
    return {amp, mean, sig};
  endfunction

  // x near a segment's mean, scaled by its sigma so z covers the curve
  function automatic logic [15:0] x_near(input logic [47:0] p);
    int sig, off;
    sig = $signed(p[15:0]);
    if (sig < 0) sig = -sig;
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    off = (sig * $signed(10'($urandom_range(0, 1023)) )) / 56;
    return 16'($signed(p[31:16]) + off);
  endfunction

  function automatic logic [15:0] rand_sigma();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(1, 8));
      1: return 16'h8000;
      2: return 16'($urandom);
      3: return -16'($urandom_range(1, 300));
      default: return 16'($urandom_range(1, 2000));
    endcase
  endfunction

  // --- stimulus --------------------------------------------------------------
  initial begin
    logic [15:0] b1, b2;
    int unsigned phase_items;
    cycles = 0; errors = 0; items_sent = 0; results_seen = 0;
    hold_req = 0; pause_tx = 0;
    push = 0; pop = 0; x_value_i = 0;
    cfg_valid_i = 0; cfg_index_i = 0; cfg_data_i = 0;
    for (int i = 0; i < DEPTH; i++) begin
      pow2_frac[i] = taylor_exp_neg((Ln2Q32 * i + DEPTH / 2) / DEPTH);
      pow2_frac[i] = (pow2_frac[i] + (64'd1 << (31 - DW))) >> (32 - DW);
    end
    for (int i = 0; i < 3; i++) gauss_reg[i] = 48'd1;
    bounds_reg = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values: amp 0 everywhere
    x_pending.push_back(16'h8000);
    x_pending.push_back(16'h0000);
    x_pending.push_back(16'h7FFF);
    drain_all();

    // directed: full amplitude, peak, tails, zero and negative sigma
    write_reg(RegLow,   gauss_word(16'hFFFF, 16'hF000, 16'd100));
    write_reg(RegMid,   gauss_word(16'd40000, 16'd0, 16'h8000));
    write_reg(RegHigh,  gauss_word(16'd1234, 16'd5000, 16'd0));
    write_reg(RegBound, {16'hE000, 16'd2000});
    write_reg(3'd5, 48'hFFFF_FFFF_FFFF);   // index beyond range, ignored
    write_reg(3'd7, 48'd0);
    x_pending.push_back(16'hF000);          // low segment's mean, classified mid
    x_pending.push_back(16'hF064);          // low mean + 1 low sigma, classified mid
    x_pending.push_back(16'hF320);          // low mean + 8 low sigma, classified mid
    x_pending.push_back(16'hE000);          // on first boundary
    x_pending.push_back(16'hE001);          // just above it
    x_pending.push_back(16'h8000);
    x_pending.push_back(16'd0);
    x_pending.push_back(16'd2000);
    x_pending.push_back(16'd2001);          // high, zero sigma
    x_pending.push_back(16'h7FFF);
    x_pending.push_back(16'h5555);
    x_pending.push_back(16'hAAAA);
    drain_all();

    write_reg(RegHigh,  gauss_word(16'hFFFF, 16'h7FFF, 16'hFFFF)); // sigma -1
    write_reg(RegBound, {16'd1000, 16'hFC00});                       // crossed
    x_pending.push_back(16'd999);
    x_pending.push_back(16'd1000);
    x_pending.push_back(16'd1001);           // crossed: high segment
    x_pending.push_back(16'h7FFF);
    x_pending.push_back(16'h7FFE);
    x_pending.push_back(16'h8000);
    drain_all();

    // random phases with fresh registers
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(RegLow,  gauss_word(16'($urandom), 16'($urandom), rand_sigma()));
      write_reg(RegMid,  gauss_word(16'($urandom), 16'($urandom), rand_sigma()));
      write_reg(RegHigh, gauss_word(ph == 0 ? 16'hFFFF : 16'($urandom),
                                    16'($urandom), rand_sigma()));
      b1 = 16'($urandom);
      b2 = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($signed(b1) + $urandom_range(0, 20000));
      if (ph == 9) begin
        b1 = 16'h7FFF; b2 = 16'h7FFF;
      end else if (ph == 8) begin
        b1 = 16'h8000; b2 = 16'h8000;
      end
      write_reg(RegBound, {b1, b2});
      phase_items = 100;
      for (int k = 0; k < phase_items; k++)
        x_pending.push_back(x_near(gauss_reg[$urandom_range(0, 2)]));
      // long pop hold-off while the sender keeps offering
      if (ph == 2) hold_req = 1'b1;
      // sender pause until all results are back
      if (ph == 5) begin
        while (x_pending.size() > 50) @(posedge clk_i);
        pause_tx = 1'b1;
        while (push || curve_expected.size() != 0) @(posedge clk_i);
        pause_tx = 1'b0;
      end
      drain_all();
    end

    $display("sent %0d x items over 13 register settings, checked %0d results",
             items_sent, results_seen);
    if (errors == 0 && curve_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
